// ----- design/sacm_pkg.sv -----
// Shared command and status types for the set-associative cache controller and datapath.
package sacm_pkg;

    // Commands from the controller to the datapath, one cycle at a time.
    typedef struct packed {
        logic       clear;       // clear one backing-memory byte and one valid row
        logic       latch;       // capture the incoming transaction
        logic       tag_rd;      // read the valid and tag rows of a set
        logic       sel2;        // look up the following line instead of the first
        logic       save1;       // keep the result of the first lookup
        logic       save2;       // keep the result of the second lookup
        logic       mem_rd;      // read one access byte from backing memory
        logic       mem_wr;      // write one access byte to backing memory
        logic       line_rd;     // read one access byte from a cached line
        logic       line_wr;     // write one access byte into a cached line
        logic       fill_start;  // restart the line fill counter
        logic       fill_rd;     // read one fill byte from backing memory
        logic       fill_sel2;   // the fill targets the following line
        logic       fill_tag;    // mark the filled way valid and write its tag
        logic       out_load;    // load the result registers
        logic [1:0] idx;         // byte index within the access
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic       is_write;
        logic       look_hit;    // combinational hit of the lookup now being evaluated
        logic       hit1;
        logic       cross_line;  // access runs past the end of its line
        logic [2:0] len;
        logic [2:0] n1;          // bytes that fall in the first line
        logic       fill_last;
        logic       clr_last;
    } sts_t;

endpackage

// ----- design/sacm_datapath.sv -----
// Datapath of the cache: backing memory, line storage, tag and valid rows, result registers.
module sacm_datapath import sacm_pkg::*; #(
    parameter int MEM_ADDR_BITS = 20,
    parameter int WAYS          = 8,
    parameter int SETS          = 128,
    parameter int LINE_BYTES    = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_action,
    input  logic [MEM_ADDR_BITS-1:0] s_address,
    input  logic [2:0]               s_length,
    input  logic [31:0]              s_write_data,
    input  logic [2:0]               s_victim_way,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic [31:0]              m_read_data,
    output logic                     m_first_hit,
    output logic                     m_second_touched,
    output logic                     m_second_hit
);

    localparam int AW       = MEM_ADDR_BITS;
    localparam int OFF_W    = $clog2(LINE_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int SIDX_W   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W    = AW - OFF_W - SET_BITS;
    localparam int LN_W     = (SETS * WAYS > 1) ? $clog2(SETS * WAYS) : 1;
    localparam int LD_W     = LN_W + OFF_W;
    localparam int MEM_BYTES = 1 << AW;
    localparam int LINES    = SETS * WAYS;
    localparam int LD_DEPTH = LINES * LINE_BYTES;

    // Storage.
    logic [7:0]            mem       [MEM_BYTES];
    logic [7:0]            line_mem  [LD_DEPTH];
    logic [WAYS-1:0]       vld_mem   [SETS];
    logic [WAYS*TAG_W-1:0] tag_mem   [SETS];

    logic [7:0]            mem_q;
    logic [7:0]            line_q;
    logic [WAYS-1:0]       vld_q;
    logic [WAYS*TAG_W-1:0] tag_q;

    // Transaction registers.
    logic          write_reg;
    logic [AW-1:0] addr_reg;
    logic [2:0]    len_reg;
    logic [31:0]   data_reg;
    logic [WAY_W-1:0] vic_reg;

    logic             hit1_reg, hit2_reg;
    logic [WAY_W-1:0] way1_reg, way2_reg, fill_way_reg;
    logic [31:0]      rd_reg;

    logic             cap_mem_reg, cap_line_reg;
    logic [1:0]       cap_idx_reg;
    logic             fwr_reg;
    logic [OFF_W-1:0] fwr_idx_reg;
    logic [OFF_W-1:0] fill_cnt_reg;
    logic [AW-1:0]    clr_cnt_reg;

    logic [31:0] out_data_reg;
    logic        out_hit1_reg, out_touch_reg, out_hit2_reg;

    // Victim way modulo the number of ways, by repeated subtraction on a 3-bit value.
    function automatic logic [WAY_W-1:0] victim_mod(input logic [2:0] v);
        logic [3:0] r;
        r = {1'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (r >= 4'(WAYS)) begin
                r = r - 4'(WAYS);
            end
        end
        return WAY_W'(r);
    endfunction

    function automatic logic [SIDX_W-1:0] set_of(input logic [AW-1:0] a);
        return SIDX_W'((a >> OFF_W) % SETS);
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [AW-1:0] a);
        return TAG_W'(a >> (OFF_W + SET_BITS));
    endfunction

    function automatic logic [LN_W-1:0] line_of(input logic [SIDX_W-1:0] s,
                                                input logic [WAY_W-1:0] w);
        return LN_W'(LN_W'(s) * LN_W'(WAYS) + LN_W'(w));
    endfunction

    // Address split of the access.
    logic [OFF_W-1:0] off;
    logic [OFF_W:0]   off_len;
    logic [2:0]       n1;
    logic [AW-1:0]    next_addr;
    logic             cross_line;

    assign off        = addr_reg[OFF_W-1:0];
    assign off_len    = (OFF_W+1)'(off) + (OFF_W+1)'(len_reg);
    assign n1         = (off_len <= (OFF_W+1)'(LINE_BYTES)) ? len_reg
                      : 3'((OFF_W+1)'(LINE_BYTES) - (OFF_W+1)'(off));
    assign next_addr  = addr_reg + AW'(n1);
    assign cross_line = len_reg > n1;

    // Lookup evaluation on the registered valid and tag rows.
    logic [AW-1:0]    look_addr;
    logic [TAG_W-1:0] look_tag;
    logic             look_hit, any_free;
    logic [WAY_W-1:0] look_way, free_way, fill_way;

    assign look_addr = cmd.sel2 ? next_addr : addr_reg;
    assign look_tag  = tag_of(look_addr);

    always_comb begin
        look_hit = 1'b0;
        look_way = '0;
        any_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vld_q[w] && tag_q[w*TAG_W +: TAG_W] == look_tag) begin
                look_hit = 1'b1;
                look_way = WAY_W'(w);
            end
            if (!vld_q[w]) begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        fill_way = any_free ? free_way : vic_reg;
    end

    // Byte addresses for the current command.
    logic [AW-1:0]    byte_addr, fill_addr, fill_base, fill_rd_addr, mem_addr;
    logic [LN_W-1:0]  line1, line2, fline;
    logic [LD_W-1:0]  acc_ld_addr, ld_addr;
    logic [2:0]       idx3;
    logic [7:0]       wr_byte;

    assign idx3         = {1'b0, cmd.idx};
    assign byte_addr    = addr_reg + AW'(cmd.idx);
    assign fill_addr    = cmd.fill_sel2 ? next_addr : addr_reg;
    assign fill_base    = {fill_addr[AW-1:OFF_W], OFF_W'(0)};
    assign fill_rd_addr = fill_base + AW'(fill_cnt_reg);
    assign line1        = line_of(set_of(addr_reg), way1_reg);
    assign line2        = line_of(set_of(next_addr), way2_reg);
    assign fline        = line_of(set_of(fill_addr), fill_way_reg);
    assign wr_byte      = 8'(data_reg >> {cmd.idx, 3'b000});

    always_comb begin
        if (idx3 < n1) begin
            acc_ld_addr = {line1, off + OFF_W'(cmd.idx)};
        end else begin
            acc_ld_addr = {line2, OFF_W'(idx3 - n1)};
        end
    end

    assign ld_addr  = fwr_reg ? {fline, fwr_idx_reg} : acc_ld_addr;
    assign mem_addr = cmd.clear ? clr_cnt_reg : (cmd.fill_rd ? fill_rd_addr : byte_addr);

    // Backing memory: one byte port.
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mem[mem_addr] <= 8'd0;
        end else if (cmd.mem_wr) begin
            mem[mem_addr] <= wr_byte;
        end else if (cmd.mem_rd || cmd.fill_rd) begin
            mem_q <= mem[mem_addr];
        end
    end

    // Line storage: one byte port.
    always_ff @(posedge aclk) begin
        if (fwr_reg) begin
            line_mem[ld_addr] <= mem_q;
        end else if (cmd.line_wr) begin
            line_mem[ld_addr] <= wr_byte;
        end else if (cmd.line_rd) begin
            line_q <= line_mem[ld_addr];
        end
    end

    // Valid and tag rows, one set per row.
    logic [WAYS*TAG_W-1:0] tag_row_new;
    logic [WAYS-1:0]       vld_row_new;

    always_comb begin
        tag_row_new = tag_q;
        tag_row_new[fill_way_reg*TAG_W +: TAG_W] = tag_of(fill_addr);
        vld_row_new = vld_q | (WAYS'(1) << fill_way_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            vld_mem[set_of(clr_cnt_reg << OFF_W)] <= '0;
        end else if (cmd.fill_tag) begin
            vld_mem[set_of(fill_addr)] <= vld_row_new;
            tag_mem[set_of(fill_addr)] <= tag_row_new;
        end else if (cmd.tag_rd) begin
            vld_q <= vld_mem[set_of(look_addr)];
            tag_q <= tag_mem[set_of(look_addr)];
        end
    end

    // Transaction payload.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            write_reg <= s_action;
            addr_reg  <= s_address;
            data_reg  <= s_write_data;
            vic_reg   <= victim_mod(s_victim_way);
            if (s_length == 3'd0) begin
                len_reg <= 3'd1;
            end else if (s_length > 3'd4) begin
                len_reg <= 3'd4;
            end else begin
                len_reg <= s_length;
            end
        end
        if (cmd.save1) begin
            way1_reg     <= look_way;
            fill_way_reg <= fill_way;
        end
        if (cmd.save2) begin
            way2_reg     <= look_way;
            fill_way_reg <= fill_way;
        end
        if (cmd.out_load) begin
            out_data_reg  <= rd_reg;
            out_hit1_reg  <= hit1_reg;
            out_touch_reg <= hit1_reg & cross_line;
            out_hit2_reg  <= hit2_reg;
        end
    end

    // Hit flags and assembled read data.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            hit1_reg <= 1'b0;
            hit2_reg <= 1'b0;
            rd_reg   <= '0;
        end else begin
            if (cmd.save1) begin
                hit1_reg <= look_hit;
            end
            if (cmd.save2) begin
                hit2_reg <= look_hit;
            end
            if (cap_mem_reg) begin
                rd_reg[{cap_idx_reg, 3'b000} +: 8] <= mem_q;
            end else if (cap_line_reg) begin
                rd_reg[{cap_idx_reg, 3'b000} +: 8] <= line_q;
            end
        end
    end

    // Read capture and fill write-back in the cycle after the reads, plus the fill and clear counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_mem_reg  <= 1'b0;
            cap_line_reg <= 1'b0;
            fwr_reg      <= 1'b0;
            fill_cnt_reg <= '0;
            clr_cnt_reg  <= '0;
        end else begin
            cap_mem_reg  <= cmd.mem_rd;
            cap_line_reg <= cmd.line_rd;
            fwr_reg      <= cmd.fill_rd;
            if (cmd.fill_start) begin
                fill_cnt_reg <= '0;
            end else if (cmd.fill_rd) begin
                fill_cnt_reg <= fill_cnt_reg + OFF_W'(1);
            end
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        cap_idx_reg <= cmd.idx;
        fwr_idx_reg <= fill_cnt_reg;
    end

    // Status to the controller.
    always_comb begin
        sts.is_write   = write_reg;
        sts.look_hit   = look_hit;
        sts.hit1       = hit1_reg;
        sts.cross_line = cross_line;
        sts.len        = len_reg;
        sts.n1         = n1;
        sts.fill_last  = fill_cnt_reg == OFF_W'(LINE_BYTES - 1);
        sts.clr_last   = clr_cnt_reg == AW'(MEM_BYTES - 1);
    end

    assign m_read_data      = out_data_reg;
    assign m_first_hit      = out_hit1_reg;
    assign m_second_touched = out_touch_reg;
    assign m_second_hit     = out_hit2_reg;

endmodule

// ----- design/sacm_ctrl.sv -----
// Controller state machine that sequences the memory clear after reset, lookups, byte accesses and line fills.
module sacm_ctrl import sacm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_LK1, ST_EV1, ST_MWR, ST_LWR1, ST_LK2, ST_EV2,
        ST_LWR2, ST_LRD1, ST_LRD2, ST_MRD, ST_DRAIN, ST_FILL, ST_FILLT, ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       fsel_reg, fsel_next;
    logic       m_valid_reg, m_valid_next;

    logic last_len, last_n1, out_free;

    assign last_len = cnt_reg == 3'(sts.len - 3'd1);
    assign last_n1  = cnt_reg == 3'(sts.n1 - 3'd1);
    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        fsel_next    = fsel_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.idx      = cnt_reg[1:0];
        cmd.fill_sel2 = fsel_reg;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_LK1;
                end
            end
            ST_LK1: begin
                cmd.tag_rd = 1'b1;
                state_next = ST_EV1;
            end
            ST_EV1: begin
                cmd.save1 = 1'b1;
                cnt_next  = 3'd0;
                fsel_next = 1'b0;
                if (sts.is_write) begin
                    state_next = ST_MWR;
                end else if (sts.look_hit) begin
                    state_next = ST_LRD1;
                end else begin
                    state_next = ST_MRD;
                end
            end
            ST_MWR: begin
                cmd.mem_wr = 1'b1;
                cnt_next   = cnt_reg + 3'd1;
                if (last_len) begin
                    cnt_next   = 3'd0;
                    state_next = sts.hit1 ? ST_LWR1 : ST_DONE;
                end
            end
            ST_LWR1: begin
                cmd.line_wr = 1'b1;
                cnt_next    = cnt_reg + 3'd1;
                if (last_n1) begin
                    state_next = sts.cross_line ? ST_LK2 : ST_DONE;
                end
            end
            ST_LK2: begin
                cmd.tag_rd = 1'b1;
                cmd.sel2   = 1'b1;
                state_next = ST_EV2;
            end
            ST_EV2: begin
                cmd.sel2  = 1'b1;
                cmd.save2 = 1'b1;
                cnt_next  = sts.n1;
                if (sts.is_write) begin
                    state_next = sts.look_hit ? ST_LWR2 : ST_DONE;
                end else if (sts.look_hit) begin
                    state_next = ST_LRD2;
                end else begin
                    fsel_next  = 1'b1;
                    state_next = ST_MRD;
                end
            end
            ST_LWR2: begin
                cmd.line_wr = 1'b1;
                cnt_next    = cnt_reg + 3'd1;
                if (last_len) begin
                    state_next = ST_DONE;
                end
            end
            ST_LRD1: begin
                cmd.line_rd = 1'b1;
                cnt_next    = cnt_reg + 3'd1;
                if (last_n1) begin
                    state_next = sts.cross_line ? ST_LK2 : ST_DRAIN;
                end
            end
            ST_LRD2: begin
                cmd.line_rd = 1'b1;
                cnt_next    = cnt_reg + 3'd1;
                if (last_len) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_MRD: begin
                cmd.mem_rd = 1'b1;
                cnt_next   = cnt_reg + 3'd1;
                if (last_len) begin
                    cmd.fill_start = 1'b1;
                    state_next     = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_rd = 1'b1;
                if (sts.fill_last) begin
                    state_next = ST_FILLT;
                end
            end
            ST_FILLT: begin
                cmd.fill_tag = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            cnt_reg     <= 3'd0;
            fsel_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            fsel_reg    <= fsel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

// ----- design/set_associative_cache_model_core.sv -----
// Top level of the set-associative write-through cache with its backing memory.
// After reset the block first clears its backing memory and all valid bits, one byte
// and one set a cycle, and accepts no transaction until then. One transaction is
// processed at a time; the next one is accepted while a result still waits. Backing
// memory and line storage each have a single byte-wide port, so every access moves one
// byte at a time: a read hit reads its bytes from the line, a write writes backing
// memory and then, on a hit, the line, and an access that hits and runs past its line
// looks up the following line too. A read miss reads its bytes from backing memory and
// then fills the whole line, in place of the drain that ends a read hit.
module set_associative_cache_model_core import sacm_pkg::*; #(
    parameter int MEM_ADDR_BITS = 20,
    parameter int WAYS          = 8,
    parameter int SETS          = 128,
    parameter int LINE_BYTES    = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_action,
    input  logic [MEM_ADDR_BITS-1:0] s_address,
    input  logic [2:0]               s_length,
    input  logic [31:0]              s_write_data,
    input  logic [2:0]               s_victim_way,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [31:0]              m_read_data,
    output logic                     m_first_hit,
    output logic                     m_second_touched,
    output logic                     m_second_hit
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    sacm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage and data handling.
    sacm_datapath #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS),
        .WAYS          (WAYS),
        .SETS          (SETS),
        .LINE_BYTES    (LINE_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_action         (s_action),
        .s_address        (s_address),
        .s_length         (s_length),
        .s_write_data     (s_write_data),
        .s_victim_way     (s_victim_way),
        .cmd              (cmd),
        .sts              (sts),
        .m_read_data      (m_read_data),
        .m_first_hit      (m_first_hit),
        .m_second_touched (m_second_touched),
        .m_second_hit     (m_second_hit)
    );

endmodule
